### rtl/sbst_pkg.sv
// ----------------------------------------------------------------------------
// sbst_pkg
// Shared types and constants for the segment versus box slab test.
// ----------------------------------------------------------------------------
`default_nettype none

package sbst_pkg;

  // Default coordinate width in bits.
  localparam int COORD_WIDTH_DEF = 32;

  // Fraction bits of the entry parameter and width of the result field.
  localparam int T_FRAC  = 16;
  localparam int ENTRY_W = T_FRAC + 1;

  // Entry parameter for a crossing at exactly t = 1.
  localparam logic [ENTRY_W-1:0] ENTRY_ONE = ENTRY_W'(1) << T_FRAC;

  // Control bits that travel down the pipeline with each transaction.
  typedef struct packed {
    logic valid;
    logic miss;
  } sbst_ctl_t;

endpackage

`default_nettype wire

### rtl/sbst_in_if.sv
// ----------------------------------------------------------------------------
// sbst_in_if
// Query channel: segment end points and box corners with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbst_in_if #(
  parameter int CW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] start_z;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic signed [CW-1:0] end_z;
  logic signed [CW-1:0] box_min_x;
  logic signed [CW-1:0] box_min_y;
  logic signed [CW-1:0] box_min_z;
  logic signed [CW-1:0] box_max_x;
  logic signed [CW-1:0] box_max_y;
  logic signed [CW-1:0] box_max_z;

  modport source (
    output valid, start_x, start_y, start_z, end_x, end_y, end_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

// ----------------------------------------------------------------------------
// sbst_out_if
// Result channel: hit flag and entry parameter with valid/ready.
// ----------------------------------------------------------------------------
interface sbst_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [16:0] entry_t;

  modport source (output valid, hit, entry_t, input ready);
  modport sink   (input valid, hit, entry_t, output ready);
endinterface

`default_nettype wire

### rtl/sbst_prep.sv
// ----------------------------------------------------------------------------
// sbst_prep
// Per-axis slab setup: differences, direction sign, crossing order, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module sbst_prep #(
  parameter  int CW = 32,
  localparam int DW = CW + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire sbst_pkg::sbst_ctl_t   ctl_i,
  input  wire logic signed [CW-1:0]  s_i  [3],
  input  wire logic signed [CW-1:0]  e_i  [3],
  input  wire logic signed [CW-1:0]  mn_i [3],
  input  wire logic signed [CW-1:0]  mx_i [3],
  output sbst_pkg::sbst_ctl_t        ctl_o,
  output logic signed [DW-1:0]       lo_num_o [3],
  output logic signed [DW-1:0]       lo_den_o [3],
  output logic signed [DW-1:0]       hi_num_o [3],
  output logic signed [DW-1:0]       hi_den_o [3]
);
  import sbst_pkg::*;

  logic signed [DW-1:0] a_nxt [3];
  logic signed [DW-1:0] b_nxt [3];
  logic signed [DW-1:0] den_nxt [3];
  logic [2:0]           par_nxt;
  logic [2:0]           pmiss_nxt;

  logic signed [DW-1:0] a_r [3];
  logic signed [DW-1:0] b_r [3];
  logic signed [DW-1:0] den_r [3];
  logic [2:0]           par_r;
  sbst_ctl_t            ctl1_r;
  sbst_ctl_t            ctl2_r;

  logic signed [DW-1:0] lo_num_r [3];
  logic signed [DW-1:0] lo_den_r [3];
  logic signed [DW-1:0] hi_num_r [3];
  logic signed [DW-1:0] hi_den_r [3];

  // Stage one: differences at full width, direction made positive.
  always_comb begin
    logic signed [DW-1:0] s, e, mn, mx, d, a, b;
    for (int k = 0; k < 3; k++) begin
      s  = {s_i[k][CW-1], s_i[k]};
      e  = {e_i[k][CW-1], e_i[k]};
      mn = {mn_i[k][CW-1], mn_i[k]};
      mx = {mx_i[k][CW-1], mx_i[k]};
      d  = e - s;
      a  = mn - s;
      b  = mx - s;
      par_nxt[k]   = (d == '0);
      pmiss_nxt[k] = (d == '0) && ((s < mn) || (s > mx));
      if (d < 0) begin
        a_nxt[k]   = -a;
        b_nxt[k]   = -b;
        den_nxt[k] = -d;
      end else begin
        a_nxt[k]   = a;
        b_nxt[k]   = b;
        den_nxt[k] = d;
      end
    end
  end

  // Control registers for both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl1_r.valid <= ctl_i.valid;
      ctl1_r.miss  <= ctl_i.miss | (|pmiss_nxt);
      ctl2_r       <= ctl1_r;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      den_r <= den_nxt;
      par_r <= par_nxt;
    end
  end

  // Stage two: order the crossings and clamp against [0,1].
  always_ff @(posedge clk) begin
    logic signed [DW-1:0] lo, hi;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        lo = (a_r[k] < b_r[k]) ? a_r[k] : b_r[k];
        hi = (a_r[k] < b_r[k]) ? b_r[k] : a_r[k];
        if (!par_r[k] && (lo > 0)) begin
          lo_num_r[k] <= lo;
          lo_den_r[k] <= den_r[k];
        end else begin
          lo_num_r[k] <= '0;
          lo_den_r[k] <= DW'(1);
        end
        if (!par_r[k] && (hi < den_r[k])) begin
          hi_num_r[k] <= hi;
          hi_den_r[k] <= den_r[k];
        end else begin
          hi_num_r[k] <= DW'(1);
          hi_den_r[k] <= DW'(1);
        end
      end
    end
  end

  assign ctl_o    = ctl2_r;
  assign lo_num_o = lo_num_r;
  assign lo_den_o = lo_den_r;
  assign hi_num_o = hi_num_r;
  assign hi_den_o = hi_den_r;

endmodule

`default_nettype wire

### rtl/sbst_sel.sv
// ----------------------------------------------------------------------------
// sbst_sel
// Exact ratio selection: larger of two entry bounds, smaller of two exits.
// ----------------------------------------------------------------------------
`default_nettype none

module sbst_sel #(
  parameter  int DW = 33,
  localparam int PW = 2 * DW
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire sbst_pkg::sbst_ctl_t ctl_i,
  input  wire logic signed [DW-1:0] lo_a_num_i,
  input  wire logic signed [DW-1:0] lo_a_den_i,
  input  wire logic signed [DW-1:0] lo_b_num_i,
  input  wire logic signed [DW-1:0] lo_b_den_i,
  input  wire logic signed [DW-1:0] hi_a_num_i,
  input  wire logic signed [DW-1:0] hi_a_den_i,
  input  wire logic signed [DW-1:0] hi_b_num_i,
  input  wire logic signed [DW-1:0] hi_b_den_i,
  output sbst_pkg::sbst_ctl_t      ctl_o,
  output logic signed [DW-1:0]     lo_num_o,
  output logic signed [DW-1:0]     lo_den_o,
  output logic signed [DW-1:0]     hi_num_o,
  output logic signed [DW-1:0]     hi_den_o
);
  import sbst_pkg::*;

  sbst_ctl_t            ctl1_r, ctl2_r;
  logic signed [PW-1:0] pl_ab_r, pl_ba_r, ph_ab_r, ph_ba_r;
  logic signed [DW-1:0] lan_r, lad_r, lbn_r, lbd_r;
  logic signed [DW-1:0] han_r, had_r, hbn_r, hbd_r;
  logic signed [DW-1:0] lo_num_r, lo_den_r, hi_num_r, hi_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
    end
  end

  // Stage one: cross products; denominators are always positive.
  always_ff @(posedge clk) begin
    if (en) begin
      pl_ab_r <= PW'(lo_a_num_i) * PW'(lo_b_den_i);
      pl_ba_r <= PW'(lo_b_num_i) * PW'(lo_a_den_i);
      ph_ab_r <= PW'(hi_a_num_i) * PW'(hi_b_den_i);
      ph_ba_r <= PW'(hi_b_num_i) * PW'(hi_a_den_i);
      lan_r <= lo_a_num_i;
      lad_r <= lo_a_den_i;
      lbn_r <= lo_b_num_i;
      lbd_r <= lo_b_den_i;
      han_r <= hi_a_num_i;
      had_r <= hi_a_den_i;
      hbn_r <= hi_b_num_i;
      hbd_r <= hi_b_den_i;
    end
  end

  // Stage two: keep the larger entry and the smaller exit.
  always_ff @(posedge clk) begin
    if (en) begin
      if (pl_ab_r > pl_ba_r) begin
        lo_num_r <= lan_r;
        lo_den_r <= lad_r;
      end else begin
        lo_num_r <= lbn_r;
        lo_den_r <= lbd_r;
      end
      if (ph_ab_r < ph_ba_r) begin
        hi_num_r <= han_r;
        hi_den_r <= had_r;
      end else begin
        hi_num_r <= hbn_r;
        hi_den_r <= hbd_r;
      end
    end
  end

  assign ctl_o    = ctl2_r;
  assign lo_num_o = lo_num_r;
  assign lo_den_o = lo_den_r;
  assign hi_num_o = hi_num_r;
  assign hi_den_o = hi_den_r;

endmodule

`default_nettype wire

### rtl/sbst_qdiv.sv
// ----------------------------------------------------------------------------
// sbst_qdiv
// Final interval check and restoring division of the entry bound, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sbst_qdiv #(
  parameter  int DW = 33,
  localparam int PW = 2 * DW,
  localparam int RW = DW + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire sbst_pkg::sbst_ctl_t  ctl_i,
  input  wire logic signed [DW-1:0] lo_num_i,
  input  wire logic signed [DW-1:0] lo_den_i,
  input  wire logic signed [DW-1:0] hi_num_i,
  input  wire logic signed [DW-1:0] hi_den_i,
  output logic                      valid_o,
  output logic                      hit_o,
  output logic [sbst_pkg::ENTRY_W-1:0] entry_o
);
  import sbst_pkg::*;

  // Product stage.
  sbst_ctl_t            ctlp_r;
  logic signed [PW-1:0] pl_r, ph_r;
  logic signed [DW-1:0] num_r, denp_r;

  // Division stages, index 0 is the compare stage.
  logic              vld_r  [T_FRAC+1];
  logic              hit_r  [T_FRAC+1];
  logic              full_r [T_FRAC+1];
  logic [RW-1:0]     rem_r  [T_FRAC+1];
  logic [RW-1:0]     den_r  [T_FRAC+1];
  logic [T_FRAC-1:0] q_r    [T_FRAC+1];

  logic [RW-1:0]     rem_nxt [T_FRAC];
  logic [T_FRAC-1:0] q_nxt   [T_FRAC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctlp_r <= '0;
      for (int i = 0; i <= T_FRAC; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      ctlp_r   <= ctl_i;
      vld_r[0] <= ctlp_r.valid;
      for (int i = 0; i < T_FRAC; i++) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  // One restoring step per stage.
  always_comb begin
    logic [RW-1:0] r2;
    for (int i = 0; i < T_FRAC; i++) begin
      r2 = rem_r[i] << 1;
      if (r2 >= den_r[i]) begin
        rem_nxt[i] = r2 - den_r[i];
        q_nxt[i]   = {q_r[i][T_FRAC-2:0], 1'b1};
      end else begin
        rem_nxt[i] = r2;
        q_nxt[i]   = {q_r[i][T_FRAC-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [RW-1:0] n0, d0;
    if (en) begin
      // Product stage: tmin against tmax.
      pl_r   <= PW'(lo_num_i) * PW'(hi_den_i);
      ph_r   <= PW'(hi_num_i) * PW'(lo_den_i);
      num_r  <= lo_num_i;
      denp_r <= lo_den_i;
      // Compare stage: hit decision and divider setup.
      n0 = RW'(unsigned'(num_r));
      d0 = RW'(unsigned'(denp_r));
      hit_r[0]  <= !ctlp_r.miss && (pl_r <= ph_r);
      full_r[0] <= (n0 >= d0);
      rem_r[0]  <= n0;
      den_r[0]  <= d0;
      q_r[0]    <= '0;
      for (int i = 0; i < T_FRAC; i++) begin
        hit_r[i+1]  <= hit_r[i];
        full_r[i+1] <= full_r[i];
        rem_r[i+1]  <= rem_nxt[i];
        den_r[i+1]  <= den_r[i];
        q_r[i+1]    <= q_nxt[i];
      end
    end
  end

  // Result formatting from the last stage.
  assign valid_o = vld_r[T_FRAC];
  assign hit_o   = hit_r[T_FRAC];
  assign entry_o = !hit_r[T_FRAC]  ? '0 :
                   full_r[T_FRAC]  ? ENTRY_ONE :
                   {1'b0, q_r[T_FRAC]};

endmodule

`default_nettype wire

### rtl/segment_box_slab_test.sv
// ----------------------------------------------------------------------------
// segment_box_slab_test
// Segment versus axis-aligned box intersection by the slab method, with
// exact rational comparison and a Q1.16 entry parameter.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   in_ch    sink       start, end, box min and box max, X/Y/Z, Q16.16
//   out_ch   source     hit flag, entry_t (Q1.16, 0..65536)
//
// One transaction enters per cycle unless a finished result waits at a stalled output.
// The pipeline holds two setup stages, two selection pairs of a
// multiply and a compare stage, a check stage pair and sixteen divider stages.
// Reset is synchronous and clears only the control bits, valid and miss.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_box_slab_test #(
  parameter int COORD_WIDTH = sbst_pkg::COORD_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sbst_in_if.sink     in_ch,
  sbst_out_if.source  out_ch
);
  import sbst_pkg::*;

  localparam int DW = COORD_WIDTH + 1;

  logic en;
  sbst_ctl_t ctl_in, ctl_p, ctl_s0, ctl_s1;

  logic signed [COORD_WIDTH-1:0] s_a [3], e_a [3], mn_a [3], mx_a [3];
  logic signed [DW-1:0] lo_num [3], lo_den [3], hi_num [3], hi_den [3];
  logic signed [DW-1:0] l0n, l0d, h0n, h0d, l1n, l1d, h1n, h1d;
  logic out_valid;

  // The pipeline advances unless a finished result is waiting.
  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en;
  assign ctl_in      = '{valid: in_ch.valid, miss: 1'b0};

  assign s_a[0]  = in_ch.start_x;
  assign s_a[1]  = in_ch.start_y;
  assign s_a[2]  = in_ch.start_z;
  assign e_a[0]  = in_ch.end_x;
  assign e_a[1]  = in_ch.end_y;
  assign e_a[2]  = in_ch.end_z;
  assign mn_a[0] = in_ch.box_min_x;
  assign mn_a[1] = in_ch.box_min_y;
  assign mn_a[2] = in_ch.box_min_z;
  assign mx_a[0] = in_ch.box_max_x;
  assign mx_a[1] = in_ch.box_max_y;
  assign mx_a[2] = in_ch.box_max_z;

  // Per-axis slab bounds.
  sbst_prep #(.CW(COORD_WIDTH)) u_prep (
    .clk, .rst_n, .en,
    .ctl_i(ctl_in), .s_i(s_a), .e_i(e_a), .mn_i(mn_a), .mx_i(mx_a),
    .ctl_o(ctl_p), .lo_num_o(lo_num), .lo_den_o(lo_den),
    .hi_num_o(hi_num), .hi_den_o(hi_den)
  );

  // Combine X with Y.
  sbst_sel #(.DW(DW)) u_sel_xy (
    .clk, .rst_n, .en, .ctl_i(ctl_p),
    .lo_a_num_i(lo_num[0]), .lo_a_den_i(lo_den[0]),
    .lo_b_num_i(lo_num[1]), .lo_b_den_i(lo_den[1]),
    .hi_a_num_i(hi_num[0]), .hi_a_den_i(hi_den[0]),
    .hi_b_num_i(hi_num[1]), .hi_b_den_i(hi_den[1]),
    .ctl_o(ctl_s0), .lo_num_o(l0n), .lo_den_o(l0d), .hi_num_o(h0n), .hi_den_o(h0d)
  );

  // Z passes through the zln_r/zld_r/zhn_r/zhd_r delay registers to line up with the X/Y selection.
  logic signed [DW-1:0] zln_r [2], zld_r [2], zhn_r [2], zhd_r [2];

  always_ff @(posedge clk) begin
    if (en) begin
      zln_r[0] <= lo_num[2];
      zld_r[0] <= lo_den[2];
      zhn_r[0] <= hi_num[2];
      zhd_r[0] <= hi_den[2];
      zln_r[1] <= zln_r[0];
      zld_r[1] <= zld_r[0];
      zhn_r[1] <= zhn_r[0];
      zhd_r[1] <= zhd_r[0];
    end
  end

  // Combine the X/Y result with Z.
  sbst_sel #(.DW(DW)) u_sel_z (
    .clk, .rst_n, .en, .ctl_i(ctl_s0),
    .lo_a_num_i(l0n), .lo_a_den_i(l0d),
    .lo_b_num_i(zln_r[1]), .lo_b_den_i(zld_r[1]),
    .hi_a_num_i(h0n), .hi_a_den_i(h0d),
    .hi_b_num_i(zhn_r[1]), .hi_b_den_i(zhd_r[1]),
    .ctl_o(ctl_s1), .lo_num_o(l1n), .lo_den_o(l1d), .hi_num_o(h1n), .hi_den_o(h1d)
  );

  // Interval check and entry parameter.
  sbst_qdiv #(.DW(DW)) u_qdiv (
    .clk, .rst_n, .en, .ctl_i(ctl_s1),
    .lo_num_i(l1n), .lo_den_i(l1d), .hi_num_i(h1n), .hi_den_i(h1d),
    .valid_o(out_valid), .hit_o(out_ch.hit), .entry_o(out_ch.entry_t)
  );

  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

### tb/tb_segment_box_slab_test.sv
// ----------------------------------------------------------------------------
// tb_segment_box_slab_test
// Checks the slab-method segment versus box test against an exact rational
// predictor. A directed table covers parallel axes, inverted boxes, touching,
// extreme coordinates and the t = 1 entry. Random queries follow under three
// idle patterns and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_box_slab_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sbst_pkg::*;

  localparam int CW        = COORD_WIDTH_DEF;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1900;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t s[3];
    coord_t e[3];
    coord_t mn[3];
    coord_t mx[3];
  } query_t;

  typedef struct {
    logic              hit;
    logic [ENTRY_W-1:0] entry;
  } answer_t;

  // One directed row: the query and, where known at a glance, its answer.
  typedef struct {
    query_t  q;
    logic    known;
    answer_t a;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sbst_in_if #(.CW(CW)) in_ch ();
  sbst_out_if           out_ch ();

  segment_box_slab_test #(.COORD_WIDTH(CW)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  answer_t expected_hits[$];
  int      fail_count = 0;
  int      idle_in_pct = 0;
  int      idle_out_pct = 0;
  logic    hold_off = 1'b0;
  int      quiet_cycles = 0;

  // Exact sign of a/ad - b/bd, denominators positive; 64 x 64 fits in 128.
  function automatic int frac_cmp(logic signed [63:0] an, logic signed [63:0] ad,
                                  logic signed [63:0] bn, logic signed [63:0] bd);
    logic signed [127:0] l;
    logic signed [127:0] r;
    l = 128'(an) * 128'(bd);
    r = 128'(bn) * 128'(ad);
    if (l > r) return 1;
    if (l < r) return -1;
    return 0;
  endfunction

  // Slab test predictor with the interval kept as exact fractions.
  function automatic answer_t slab_answer(query_t q);
    answer_t a;
    logic signed [63:0] lo_n, lo_d, hi_n, hi_d, d, na, nb, u;
    logic [127:0] scaled;
    a.hit = 1'b0;
    a.entry = '0;
    lo_n = 0; lo_d = 1; hi_n = 1; hi_d = 1;
    for (int k = 0; k < 3; k++) begin
      d = 64'(q.e[k]) - 64'(q.s[k]);
      if (d == 0) begin
        if (q.s[k] < q.mn[k] || q.s[k] > q.mx[k]) return a;
        continue;
      end
      na = 64'(q.mn[k]) - 64'(q.s[k]);
      nb = 64'(q.mx[k]) - 64'(q.s[k]);
      if (d < 0) begin
        d = -d; na = -na; nb = -nb;
      end
      if (na > nb) begin
        u = na; na = nb; nb = u;
      end
      if (frac_cmp(na, d, lo_n, lo_d) > 0) begin
        lo_n = na; lo_d = d;
      end
      if (frac_cmp(nb, d, hi_n, hi_d) < 0) begin
        hi_n = nb; hi_d = d;
      end
      if (frac_cmp(lo_n, lo_d, hi_n, hi_d) > 0) return a;
    end
    a.hit = 1'b1;
    if (lo_n >= lo_d) begin
      a.entry = ENTRY_ONE;
    end else begin
      scaled = (128'(lo_n) << T_FRAC) / 128'(lo_d);
      a.entry = ENTRY_W'(scaled);
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Build a query; every axis given as (s, e, min, max).
  function automatic query_t make_query(coord_t sx, coord_t ex, coord_t nx, coord_t xx,
                                        coord_t sy, coord_t ey, coord_t ny, coord_t xy,
                                        coord_t sz, coord_t ez, coord_t nz, coord_t xz);
    query_t q;
    q.s  = '{sx, sy, sz};
    q.e  = '{ex, ey, ez};
    q.mn = '{nx, ny, nz};
    q.mx = '{xx, xy, xz};
    return q;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return coord_t'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  // Random query: mostly boxes near the segment, some parallel axes and noise.
  function automatic query_t rand_query();
    query_t q;
    int mode;
    coord_t a, b;
    mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
    for (int k = 0; k < 3; k++) begin
      q.s[k] = rand_coord(mode);
      q.e[k] = ($urandom_range(0, 5) == 0) ? q.s[k] : rand_coord(mode);
      a = rand_coord(mode);
      b = rand_coord(mode);
      if ($urandom_range(0, 7) != 0 && a > b) begin
        q.mn[k] = b; q.mx[k] = a;
      end else begin
        q.mn[k] = a; q.mx[k] = b;
      end
    end
    return q;
  endfunction

  localparam coord_t CMAX = coord_t'(32'h7fffffff);
  localparam coord_t CMIN = coord_t'(32'h80000000);
  localparam coord_t ONE  = coord_t'(32'h00010000);

  row_t dir_rows[$];

  task automatic add_row(query_t q, logic known, logic hit, logic [ENTRY_W-1:0] entry);
    row_t r;
    r.q = q;
    r.known = known;
    r.a.hit = hit;
    r.a.entry = entry;
    dir_rows.push_back(r);
  endtask

  // Directed table.
  initial begin
    // Degenerate point inside unit box: hit at t = 0.
    add_row(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1, 1'b1, '0);
    // Parallel axis outside: miss.
    add_row(make_query(2*ONE, 2*ONE, 0, ONE, 0, ONE, 0, ONE, 0, ONE, 0, ONE),
            1'b1, 1'b0, '0);
    // Inverted box on a parallel axis: miss.
    add_row(make_query(0, 0, ONE, -ONE, 0, ONE, 0, ONE, 0, ONE, 0, ONE), 1'b1, 1'b0, '0);
    // Inverted box on a moving axis acts as [max, min].
    add_row(make_query(0, 4*ONE, 3*ONE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b0, 1'b0, '0);
    // Entry exactly at t = 1 (touch at the end point).
    add_row(make_query(0, ONE, ONE, 2*ONE, 0, 0, 0, ONE, 0, 0, 0, ONE),
            1'b1, 1'b1, ENTRY_ONE);
    // Entry at half way.
    add_row(make_query(0, 2*ONE, ONE, 3*ONE, 0, 0, 0, ONE, 0, 0, 0, ONE),
            1'b1, 1'b1, 17'h08000);
    // Box just past the end: miss.
    add_row(make_query(0, ONE, ONE + 1, 2*ONE, 0, 0, 0, ONE, 0, 0, 0, ONE),
            1'b1, 1'b0, '0);
    // Reverse direction.
    add_row(make_query(4*ONE, 0, ONE, 2*ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b0, 1'b0, '0);
    // Touch between two axes: tmin == tmax.
    add_row(make_query(0, 2*ONE, ONE, 3*ONE, 0, 2*ONE, -ONE, ONE, 0, 0, 0, 0),
            1'b0, 1'b0, '0);
    // Extremes: full range segment, full range box.
    add_row(make_query(CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN),
            1'b1, 1'b1, '0);
    add_row(make_query(CMAX, CMIN, 0, 0, CMIN, CMAX, -1, 1, CMAX, CMAX, CMIN, CMAX),
            1'b0, 1'b0, '0);
    add_row(make_query(CMIN, CMAX, CMAX, CMAX, 0, 0, CMIN, CMAX, 0, ONE, 0, 0),
            1'b0, 1'b0, '0);
    add_row(make_query(CMIN, CMIN, CMAX, CMAX, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, '0);
    add_row(make_query(-1, -1, -1, -1, -1, -1, -1, -1, CMAX, CMAX, CMAX, CMAX),
            1'b1, 1'b1, '0);
    // Tiny steps with fine fractions.
    add_row(make_query(0, 3, 1, 2, 0, 7, 2, 5, 0, 0, 0, 0), 1'b0, 1'b0, '0);
    add_row(make_query(0, -3, -2, -1, 5, 5, 5, 5, 1, 100, 33, 34), 1'b0, 1'b0, '0);
  end

  // Sender: walk the directed table, then random queries per idle phase.
  initial begin
    query_t q;
    in_ch.valid <= 1'b0;
    in_ch.start_x <= '0; in_ch.start_y <= '0; in_ch.start_z <= '0;
    in_ch.end_x <= '0; in_ch.end_y <= '0; in_ch.end_z <= '0;
    in_ch.box_min_x <= '0; in_ch.box_min_y <= '0; in_ch.box_min_z <= '0;
    in_ch.box_max_x <= '0; in_ch.box_max_y <= '0; in_ch.box_max_z <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_in_pct = 21;
    idle_out_pct = 50;
    foreach (dir_rows[i]) send_query(dir_rows[i].q, dir_rows[i].known, dir_rows[i].a);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        idle_in_pct = 50; idle_out_pct = 21;
      end
      if (n == 2 * N_RANDOM / 3) begin
        idle_in_pct = 0; idle_out_pct = 0;
      end
      // Mid-run long output stall while inputs keep coming.
      if (n == N_RANDOM / 2) hold_off = 1'b1;
      q = rand_query();
      send_query(q, 1'b0, '{hit: 1'b0, entry: '0});
    end
    // Drop valid right after the last accepted transaction.
    in_ch.valid <= 1'b0;
  end

  // Offer one query until accepted; each accept queues its expected answer.
  task automatic send_query(query_t q, logic known, answer_t a);
    answer_t p;
    while ($urandom_range(0, 99) < idle_in_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.start_x <= q.s[0];  in_ch.start_y <= q.s[1];  in_ch.start_z <= q.s[2];
    in_ch.end_x <= q.e[0];    in_ch.end_y <= q.e[1];    in_ch.end_z <= q.e[2];
    in_ch.box_min_x <= q.mn[0]; in_ch.box_min_y <= q.mn[1]; in_ch.box_min_z <= q.mn[2];
    in_ch.box_max_x <= q.mx[0]; in_ch.box_max_y <= q.mx[1]; in_ch.box_max_z <= q.mx[2];
    p = slab_answer(q);
    if (known && (p.hit !== a.hit || p.entry !== a.entry))
      $display("note: table row disagrees with predictor, table value used");
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_hits.push_back(known ? a : p);
  endtask

  // Receiver ready with random idling and one long hold-off.
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        for (int c = 0; c < 300; c++) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= idle_out_pct);
    end
  end

  // Result check and watchdog.
  initial begin
    answer_t w;
    int tail;
    tail = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      quiet_cycles++;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) quiet_cycles = 0;
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        quiet_cycles = 0;
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_ch.hit), 0);
        end else begin
          w = expected_hits.pop_front();
          if (out_ch.hit !== w.hit) report_mismatch("hit", 32'(out_ch.hit), 32'(w.hit));
          if (out_ch.entry_t !== w.entry)
            report_mismatch("entry_t", 32'(out_ch.entry_t), 32'(w.entry));
        end
      end
      if (quiet_cycles >= WDOG_MAX) begin
        if (expected_hits.size() != 0 || in_ch.valid === 1'b1) begin
          $display("RESULT: ERROR");
          $finish;
        end
        tail = 1;
      end
      if (expected_hits.size() == 0 && in_ch.valid !== 1'b1 && rst_n) tail++;
      else tail = 0;
      if (tail > 100) begin
        if (fail_count == 0) begin
          $display("RESULT: OK");
        end else begin
          $display("RESULT: ERROR");
        end
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

### segment_box_slab_test.f
rtl/sbst_pkg.sv
rtl/sbst_in_if.sv
rtl/sbst_prep.sv
rtl/sbst_sel.sv
rtl/sbst_qdiv.sv
rtl/segment_box_slab_test.sv
tb/tb_segment_box_slab_test.sv
